/* src/csoc_pkg.sv */
// Shared constants and types of the column statistics block.
package csoc_pkg;

	localparam int CNT_W  = 11;
	localparam int THR_W  = 12;
	localparam int Q_W    = 32;
	localparam int CLS_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [THR_W-1:0] THR_RESET = 12'd768;
	localparam int MIN_FOR_OUTLIERS = 3;

	localparam logic [CLS_W-1:0] CLS_FINITE = 2'd0;
	localparam logic [CLS_W-1:0] CLS_NAN    = 2'd1;
	localparam logic [CLS_W-1:0] CLS_INF    = 2'd2;
	localparam logic [CLS_W-1:0] CLS_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NODATA = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TRUNC  = 2'd2;

	typedef struct packed {
		logic rd_active;
		logic release_col;
	} back_stat_t;

endpackage

/* src/csoc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csoc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/csoc_fifo.sv */
// Short queue of finished column summaries between front and back.
module csoc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* src/csoc_front.sv */
// Front part: takes sample beats, counts by class, stores finite samples.
module csoc_front #(
	parameter int SB   = 24,
	parameter int MAXS = 1024,
	parameter int CW   = 11,
	parameter int SW   = 35,
	parameter int EW   = 128,
	parameter int IDW  = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IDW-1:0]             s_tdata,
	input  logic [csoc_pkg::CLS_W-1:0] s_tuser,
	input  logic                       s_tlast,
	input  logic                       release_col,
	input  logic                       fifo_full,
	output logic                       push,
	output logic [EW-1:0]              push_data,
	output logic                       ram_we,
	output logic [$clog2(MAXS)-1:0]    ram_waddr,
	output logic [SB-1:0]              ram_wdata
);

	localparam int AW = $clog2(MAXS);
	localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

	logic [CW-1:0]        all_q, fin_q, nan_q, inf_q;
	logic signed [SW-1:0] sum_q;
	logic signed [SB-1:0] min_q, max_q;
	logic                 ovf_q, lock_q;

	logic [CW-1:0]        all_n, fin_n, nan_n, inf_n;
	logic signed [SW-1:0] sum_n;
	logic signed [SB-1:0] min_n, max_n, x;
	logic                 ovf_n, acc, room, finite;

	assign x        = s_tdata[SB-1:0];
	assign s_tready = !lock_q && !fifo_full;
	assign acc      = s_tvalid && s_tready;
	assign room     = all_q < CW'(MAXS);
	assign finite   = s_tuser == csoc_pkg::CLS_FINITE;

	always_comb begin
		all_n = all_q;
		fin_n = fin_q;
		nan_n = nan_q;
		inf_n = inf_q;
		sum_n = sum_q;
		min_n = min_q;
		max_n = max_q;
		ovf_n = ovf_q;
		if (acc) begin
			if (room) begin
				all_n = all_q + 1'b1;
				priority if (finite) begin
					fin_n = fin_q + 1'b1;
					sum_n = sum_q + SW'(x);
					min_n = (x < min_q) ? x : min_q;
					max_n = (x > max_q) ? x : max_q;
				end else if (s_tuser == csoc_pkg::CLS_INF) begin
					inf_n = inf_q + 1'b1;
				end else begin
					// The unused class code counts as not-a-number.
					nan_n = nan_q + 1'b1;
				end
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	assign ram_we    = acc && room && finite;
	assign ram_waddr = fin_q[AW-1:0];
	assign ram_wdata = x;
	assign push      = acc && s_tlast;
	assign push_data = {ovf_n, max_n, min_n, sum_n, inf_n, nan_n, fin_n, all_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q  <= '0;
			fin_q  <= '0;
			nan_q  <= '0;
			inf_q  <= '0;
			sum_q  <= '0;
			min_q  <= MOST_POS;
			max_q  <= MOST_NEG;
			ovf_q  <= 1'b0;
			lock_q <= 1'b0;
		end else begin
			if (push) begin
				all_q  <= '0;
				fin_q  <= '0;
				nan_q  <= '0;
				inf_q  <= '0;
				sum_q  <= '0;
				min_q  <= MOST_POS;
				max_q  <= MOST_NEG;
				ovf_q  <= 1'b0;
				// The stored samples stay untouched until the back part has read them.
				lock_q <= 1'b1;
			end else if (acc) begin
				all_q <= all_n;
				fin_q <= fin_n;
				nan_q <= nan_n;
				inf_q <= inf_n;
				sum_q <= sum_n;
				min_q <= min_n;
				max_q <= max_n;
				ovf_q <= ovf_n;
			end
			if (release_col) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

/* src/csoc_back.sv */
// Back part: mean, second passes, square root and outlier count per column.
module csoc_back #(
	parameter int SB   = 24,
	parameter int MAXS = 1024,
	parameter int CW   = 11,
	parameter int SW   = 35,
	parameter int EW   = 128,
	parameter int ODW  = 192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [csoc_pkg::THR_W-1:0]  thr,
	input  logic                        fifo_empty,
	input  logic [EW-1:0]               fifo_data,
	output logic                        fifo_pop,
	output logic [$clog2(MAXS)-1:0]     ram_raddr,
	input  logic [SB-1:0]               ram_rdata,
	output csoc_pkg::back_stat_t        stat,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ODW-1:0]              m_tdata,
	output logic [csoc_pkg::STAT_W-1:0] m_tuser
);

	localparam int AW   = $clog2(MAXS);
	localparam int MNW  = SB + 9;
	localparam int QW   = 2 * SB;
	localparam int S2W  = QW + CW;
	localparam int NW   = S2W + CW;
	localparam int RW   = (NW + 17) / 2;
	localparam int DWE  = 2 * RW;
	localparam int MW   = SW + 8;
	localparam int DVW  = (MW > RW) ? MW : RW;
	localparam int STW  = $clog2(DVW + 1);
	localparam int LW   = csoc_pkg::THR_W + csoc_pkg::Q_W;
	localparam int DEVW = SB + 10;
	localparam int CMPW = (DEVW + 8 > LW) ? DEVW + 8 : LW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVM  = 4'd1;
	localparam logic [3:0] ST_PASS1 = 4'd2;
	localparam logic [3:0] ST_MULN  = 4'd3;
	localparam logic [3:0] ST_MULS  = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_DIVS  = 4'd6;
	localparam logic [3:0] ST_LIM   = 4'd7;
	localparam logic [3:0] ST_PASS2 = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]     st_q;
	logic [STW-1:0] step_q;
	logic           last_step;

	// Column summary taken from the queue.
	logic [CW-1:0]        all_c, fin_c, nan_c, inf_c;
	logic signed [SW-1:0] sum_c;
	logic signed [SB-1:0] min_c, max_c;
	logic                 ovf_c;
	logic [SW-1:0]        sum_mag;

	// Shared divider, multiplier and root registers.
	logic [DVW-1:0]        dq_q, dq_nx;
	logic [CW-1:0]         drem_q, drem_nx;
	logic [CW:0]           dtry;
	logic                  dge;
	logic [NW-1:0]         mcand_q, prod_q, prod_nx, ns2_q;
	logic [SW-1:0]         mplier_q;
	logic [DWE-1:0]        rad_q;
	logic [RW:0]           srem_q;
	logic [RW+2:0]         sacc, strial;
	logic                  sge;
	logic [RW-1:0]         root_q, root_nx;
	logic signed [MNW-1:0] mean_q;
	logic [csoc_pkg::Q_W-1:0] std_q;
	logic [LW-1:0]         lim_q;

	// Pass pipeline.
	logic [CW-1:0]         rd_cnt_q;
	logic                  issuing, pass_done, v1_q, v2_q;
	logic signed [SB-1:0]  xr;
	logic [SB-1:0]         xmag;
	logic [QW-1:0]         sq_s2;
	logic signed [DEVW-1:0] xs, diff;
	logic [DEVW-1:0]       dev_s2;
	logic [S2W-1:0]        s2_q;
	logic [CW-1:0]         outl_q;
	logic                  is_outl;

	logic out_load;
	logic [csoc_pkg::STAT_W-1:0] status;
	logic [SB-1:0] range_v;

	assign last_step = step_q == STW'(1);
	assign sum_mag   = sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c);

	// One restoring division step by the finite count.
	assign dtry    = {drem_q, dq_q[DVW-1]};
	assign dge     = dtry >= {1'b0, fin_c};
	assign drem_nx = dge ? CW'(dtry - {1'b0, fin_c}) : CW'(dtry);
	assign dq_nx   = {dq_q[DVW-2:0], dge};

	// One shift-and-add multiplication step.
	assign prod_nx = mplier_q[0] ? prod_q + mcand_q : prod_q;

	// One digit of the integer square root, two radicand bits per step.
	assign sacc    = {srem_q, rad_q[DWE-1 -: 2]};
	assign strial  = {1'b0, root_q, 2'b01};
	assign sge     = sacc >= strial;
	assign root_nx = {root_q[RW-2:0], sge};

	assign issuing   = (st_q == ST_PASS1 || st_q == ST_PASS2) && (rd_cnt_q < fin_c);
	assign pass_done = !issuing && !v1_q && !v2_q;
	assign ram_raddr = rd_cnt_q[AW-1:0];

	assign xr   = ram_rdata;
	assign xmag = xr[SB-1] ? SB'(~xr + 1'b1) : SB'(xr);
	assign xs   = DEVW'(xr) <<< 8;
	assign diff = xs - DEVW'(mean_q);
	assign is_outl = CMPW'({dev_s2, 8'b0}) > CMPW'(lim_q);

	assign fifo_pop = st_q == ST_IDLE && !fifo_empty;
	assign out_load = st_q == ST_OUT && (!m_tvalid || m_tready);

	assign stat.rd_active   = st_q == ST_PASS1 || st_q == ST_PASS2;
	assign stat.release_col = out_load;

	function automatic logic [SW-1:0] sum_mag_pop(input logic [EW-1:0] d);
		logic signed [SW-1:0] s;
		s = d[4*CW +: SW];
		return s[SW-1] ? SW'(-s) : SW'(s);
	endfunction

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			{ovf_c, max_c, min_c, sum_c, inf_c, nan_c, fin_c, all_c} <= fifo_data;
		end
		if (v1_q) begin
			sq_s2  <= xmag * xmag;
			dev_s2 <= diff[DEVW-1] ? DEVW'(-diff) : DEVW'(diff);
		end
		unique case (st_q)
			ST_IDLE: begin
				outl_q <= '0;
				drem_q <= '0;
				dq_q   <= DVW'({sum_mag_pop(fifo_data), 8'b0});
			end
			ST_DIVM: begin
				drem_q <= drem_nx;
				dq_q   <= dq_nx;
				if (last_step) begin
					mean_q   <= sum_c[SW-1] ? -MNW'(dq_nx) : MNW'(dq_nx);
					rd_cnt_q <= '0;
					s2_q     <= '0;
				end
			end
			ST_PASS1: begin
				if (issuing) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (v2_q) begin
					s2_q <= s2_q + S2W'(sq_s2);
				end
				if (pass_done) begin
					prod_q   <= '0;
					mcand_q  <= NW'(s2_q);
					mplier_q <= SW'(fin_c);
				end
			end
			ST_MULN, ST_MULS: begin
				if (last_step && st_q == ST_MULN) begin
					ns2_q    <= prod_nx;
					prod_q   <= '0;
					mcand_q  <= NW'(sum_mag);
					mplier_q <= sum_mag;
				end else begin
					prod_q   <= prod_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				if (last_step && st_q == ST_MULS) begin
					rad_q  <= DWE'({ns2_q - prod_nx, 16'b0});
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				srem_q <= sge ? (RW+1)'(sacc - strial) : (RW+1)'(sacc);
				root_q <= root_nx;
				if (last_step) begin
					dq_q   <= DVW'(root_nx);
					drem_q <= '0;
				end
			end
			ST_DIVS: begin
				drem_q <= drem_nx;
				dq_q   <= dq_nx;
				if (last_step) begin
					std_q <= csoc_pkg::Q_W'(dq_nx);
				end
			end
			ST_LIM: begin
				lim_q    <= LW'(thr) * LW'(std_q);
				rd_cnt_q <= '0;
			end
			ST_PASS2: begin
				if (issuing) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (v2_q && is_outl) begin
					outl_q <= outl_q + 1'b1;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= '0;
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
		end else begin
			v1_q <= issuing;
			v2_q <= v1_q;
			unique case (st_q)
				ST_IDLE: begin
					if (fifo_pop) begin
						if (fifo_data[CW +: CW] == '0) begin
							st_q <= ST_OUT;
						end else begin
							st_q   <= ST_DIVM;
							step_q <= STW'(DVW);
						end
					end
				end
				ST_DIVM: begin
					step_q <= step_q - 1'b1;
					if (last_step) begin
						st_q <= ST_PASS1;
					end
				end
				ST_PASS1: begin
					if (pass_done) begin
						st_q   <= ST_MULN;
						step_q <= STW'(CW);
					end
				end
				ST_MULN: begin
					if (last_step) begin
						st_q   <= ST_MULS;
						step_q <= STW'(SW);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_MULS: begin
					if (last_step) begin
						st_q   <= ST_SQRT;
						step_q <= STW'(RW);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (last_step) begin
						st_q   <= ST_DIVS;
						step_q <= STW'(DVW);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DIVS: begin
					step_q <= step_q - 1'b1;
					if (last_step) begin
						st_q <= ST_LIM;
					end
				end
				ST_LIM: begin
					st_q <= (fin_c >= CW'(csoc_pkg::MIN_FOR_OUTLIERS)) ? ST_PASS2 : ST_OUT;
				end
				ST_PASS2: begin
					if (pass_done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status = (fin_c == '0) ? csoc_pkg::STAT_NODATA :
		(ovf_c ? csoc_pkg::STAT_TRUNC : csoc_pkg::STAT_OK);
	assign range_v = SB'(max_c - min_c);

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= status;
			if (fin_c == '0) begin
				m_tdata <= ODW'({CW'(0), 1'b0, csoc_pkg::CNT_W'(0), {(3*SB){1'b0}},
					{(2*csoc_pkg::Q_W){1'b0}}, csoc_pkg::CNT_W'(inf_c),
					csoc_pkg::CNT_W'(nan_c), csoc_pkg::CNT_W'(fin_c),
					csoc_pkg::CNT_W'(all_c)}) ;
			end else begin
				m_tdata <= ODW'({outl_q != '0, csoc_pkg::CNT_W'(outl_q), range_v, max_c,
					min_c, std_q, csoc_pkg::Q_W'(mean_q), csoc_pkg::CNT_W'(inf_c),
					csoc_pkg::CNT_W'(nan_c), csoc_pkg::CNT_W'(fin_c),
					csoc_pkg::CNT_W'(all_c)});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule

/* src/column_statistics_outlier_count.sv */
// Top level of the column statistics and outlier count block.
// Samples are taken one beat per cycle while s_tready is high; the tlast beat closes
// the column. The result follows mean division, first pass, two multiplies, root and
// deviation division (W divider and RW root steps, both 43; CW 11, SW 35 at defaults),
// then the outlier pass if three or more samples are finite; with none, all is skipped.
// Input stalls from tlast until the result is loaded; reset clears the front counts.
module column_statistics_outlier_count #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	// s_tdata: sample_value
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// s_tuser: sample_class
	input  logic [csoc_pkg::CLS_W-1:0] s_tuser,
	input  logic                       s_tlast,
	// m_tdata: total count, finite count, NaN count, infinity count, mean_value,
	// std_deviation, min_value, max_value, value_range, outlier tally, outliers_found
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [((120+3*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// m_tuser: column_status
	output logic [csoc_pkg::STAT_W-1:0] m_tuser,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [csoc_pkg::THR_W-1:0] cfg_data
);

	localparam int IDW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int ODW = ((120 + 3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SW  = SAMPLE_BITS + CW;
	localparam int EW  = 1 + 2 * SAMPLE_BITS + SW + 4 * CW;

	logic [csoc_pkg::THR_W-1:0] thr_q;
	logic                       fifo_push, fifo_full, fifo_pop, fifo_empty;
	logic [EW-1:0]              push_data, pop_data;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0]     ram_wdata, ram_rdata;
	csoc_pkg::back_stat_t       bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= csoc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	csoc_front #(
		.SB(SAMPLE_BITS), .MAXS(MAX_SAMPLES), .CW(CW), .SW(SW), .EW(EW), .IDW(IDW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.release_col(bstat.release_col), .fifo_full(fifo_full),
		.push(fifo_push), .push_data(push_data),
		.ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata)
	);

	csoc_fifo #(.WIDTH(EW), .DEPTH(2)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(fifo_push), .push_data(push_data), .full(fifo_full),
		.pop(fifo_pop), .pop_data(pop_data), .empty(fifo_empty)
	);

	csoc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	csoc_back #(
		.SB(SAMPLE_BITS), .MAXS(MAX_SAMPLES), .CW(CW), .SW(SW), .EW(EW), .ODW(ODW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .thr(thr_q),
		.fifo_empty(fifo_empty), .fifo_data(pop_data), .fifo_pop(fifo_pop),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata), .stat(bstat),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	a_no_write_during_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && bstat.rd_active)) else $error("sample RAM written during a read pass");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full) else $error("column queue overrun");

	a_nodata_zero_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == csoc_pkg::STAT_NODATA) |->
		m_tdata[2*csoc_pkg::CNT_W-1:csoc_pkg::CNT_W] == '0)
		else $error("no-data status with nonzero valid count");

endmodule
